// ----- hdl/tfwm_pkg.sv -----
// Shared constants and types for the topic filter wildcard matcher.
`timescale 1ns / 1ps

package tfwm_pkg;

  // Default capacity of each string buffer, in bytes.
  localparam int DEF_MAX_STRING_BYTES = 100;

  // Special bytes of the topic and filter syntax.
  localparam logic [7:0] SEP_BYTE       = 8'h2F;  // '/'
  localparam logic [7:0] ANY_REST_BYTE  = 8'h2A;  // '*'
  localparam logic [7:0] ONE_LEVEL_BYTE = 8'h2B;  // '+'

  // Input operation codes.
  typedef enum logic [1:0] {
    OP_TOPIC  = 2'd0,
    OP_FILTER = 2'd1,
    OP_EVAL   = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  // Control bundle from the sequencer to one string buffer.
  typedef struct packed {
    logic       append;
    logic       clear;
    logic [7:0] data;
  } buf_ctl_t;

endpackage

// ----- hdl/topic_filter_wildcard_match.sv -----
// Top level of the topic filter wildcard matcher: intake, walk sequencer, result register.
//
//   Channel | Handshake             | Payload          | Moves
//   --------+-----------------------+------------------+--------------------------------
//   in      | in_valid / in_stall   | op, char_byte    | append topic/filter byte, eval
//   out     | out_valid / out_stall | is_match         | one result per evaluate
//
// Appends are accepted back to back whenever the sequencer is idle.
// An evaluate walks the two buffers through one shared byte compare; each step first
// lets the registered buffer read data settle. When the two lengths agree, an
// equality pass runs first, and a mismatch there hands over to the level pass.
// The walk ends by loading the result register.
// Reset (rst, synchronous) empties both buffers and drops any pending result.
// in_stall is high for the whole evaluate walk and while a finished result waits for
// a full output register; appends are accepted while an earlier result is still held.
`timescale 1ns / 1ps

module topic_filter_wildcard_match #(
  parameter int MAX_STRING_BYTES = tfwm_pkg::DEF_MAX_STRING_BYTES
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] op,
  input  logic [7:0] char_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       is_match
);
  import tfwm_pkg::*;

  localparam int LW = $clog2(MAX_STRING_BYTES + 1);

  // Sequencer states. When the two lengths agree the equality pass runs first; the level
  // pass alternates between skipping separators and checking one filter level.
  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_EQ    = 9'b000000010,
    S_TSKIP = 9'b000000100,
    S_FSKIP = 9'b000001000,
    S_FLVL  = 9'b000010000,
    S_FEND  = 9'b000100000,
    S_CMP   = 9'b001000000,
    S_TLVL  = 9'b010000000,
    S_FIN   = 9'b100000000
  } state_t;

  state_t        state, state_next;
  logic          primed, primed_next;
  logic [LW-1:0] tp, tp_next;
  logic [LW-1:0] fp, fp_next;
  logic          have_t, have_t_next;
  logic          spec_any, spec_any_next;
  logic          res, res_next;

  logic          in_accept;
  logic          fin_load;
  logic          walking;
  buf_ctl_t      topic_ctl, filter_ctl;
  logic [7:0]    t_byte, f_byte;
  logic [LW-1:0] topic_len, filter_len;
  logic          t_past, f_past;
  logic          t_end, f_end;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;

  // The result register is free when it is empty or being drained this cycle.
  assign fin_load = (state == S_FIN) && (!out_valid || !out_stall);

  assign walking = (state != S_IDLE) && (state != S_FIN);

  assign topic_ctl.append  = in_accept && (op == OP_TOPIC);
  assign topic_ctl.clear   = fin_load;
  assign topic_ctl.data    = char_byte;
  assign filter_ctl.append = in_accept && (op == OP_FILTER);
  assign filter_ctl.clear  = fin_load;
  assign filter_ctl.data   = char_byte;

  tfwm_buf #(
    .MAX_STRING_BYTES(MAX_STRING_BYTES),
    .LW              (LW)
  ) u_topic (
    .clk    (clk),
    .rst    (rst),
    .ctl    (topic_ctl),
    .rd_addr(tp),
    .rd_data(t_byte),
    .len    (topic_len)
  );

  tfwm_buf #(
    .MAX_STRING_BYTES(MAX_STRING_BYTES),
    .LW              (LW)
  ) u_filter (
    .clk    (clk),
    .rst    (rst),
    .ctl    (filter_ctl),
    .rd_addr(fp),
    .rd_data(f_byte),
    .len    (filter_len)
  );

  // A position is at the end of its level when it is past the string or on a separator.
  assign t_past = (tp >= topic_len);
  assign f_past = (fp >= filter_len);
  assign t_end  = t_past || (t_byte == SEP_BYTE);
  assign f_end  = f_past || (f_byte == SEP_BYTE);

  // Every walk state first lets the read data settle for the current
  // pointers (primed low) and then acts on it (primed high).
  always_comb begin
    state_next    = state;
    tp_next       = tp;
    fp_next       = fp;
    have_t_next   = have_t;
    spec_any_next = spec_any;
    res_next      = res;
    primed_next   = walking && !primed;

    unique case (state)
      S_IDLE: begin
        if (in_accept && (op == OP_EVAL)) begin
          tp_next    = '0;
          fp_next    = '0;
          state_next = (topic_len == filter_len) ? S_EQ : S_TSKIP;
        end
      end
      S_EQ: begin
        if (primed) begin
          if (t_past) begin
            res_next   = 1'b1;
            state_next = S_FIN;
          end else if (t_byte != f_byte) begin
            tp_next    = '0;
            fp_next    = '0;
            state_next = S_TSKIP;
          end else begin
            tp_next = tp + LW'(1);
            fp_next = fp + LW'(1);
          end
        end
      end
      S_TSKIP: begin
        if (primed) begin
          if (t_past) begin
            have_t_next = 1'b0;
            state_next  = S_FSKIP;
          end else if (t_byte == SEP_BYTE) begin
            tp_next = tp + LW'(1);
          end else begin
            have_t_next = 1'b1;
            state_next  = S_FSKIP;
          end
        end
      end
      S_FSKIP: begin
        if (primed) begin
          if (f_past) begin
            res_next   = !have_t;
            state_next = S_FIN;
          end else if (f_byte == SEP_BYTE) begin
            fp_next = fp + LW'(1);
          end else begin
            state_next = S_FLVL;
          end
        end
      end
      S_FLVL: begin
        if (primed) begin
          if ((f_byte == ANY_REST_BYTE) || (f_byte == ONE_LEVEL_BYTE)) begin
            spec_any_next = (f_byte == ANY_REST_BYTE);
            fp_next       = fp + LW'(1);
            state_next    = S_FEND;
          end else if (!have_t) begin
            res_next   = 1'b0;
            state_next = S_FIN;
          end else begin
            state_next = S_CMP;
          end
        end
      end
      S_FEND: begin
        if (primed) begin
          if (f_end) begin
            if (spec_any) begin
              res_next   = 1'b1;
              state_next = S_FIN;
            end else if (!have_t) begin
              res_next   = 1'b0;
              state_next = S_FIN;
            end else begin
              state_next = S_TLVL;
            end
          end else if (!have_t) begin
            res_next   = 1'b0;
            state_next = S_FIN;
          end else begin
            // The wildcard byte opens a longer level; compare it from its start.
            fp_next    = fp - LW'(1);
            state_next = S_CMP;
          end
        end
      end
      S_CMP: begin
        if (primed) begin
          if (t_end && f_end) begin
            state_next = S_TSKIP;
          end else if (t_end || f_end || (t_byte != f_byte)) begin
            res_next   = 1'b0;
            state_next = S_FIN;
          end else begin
            tp_next = tp + LW'(1);
            fp_next = fp + LW'(1);
          end
        end
      end
      S_TLVL: begin
        if (primed) begin
          if (t_end) begin
            state_next = S_TSKIP;
          end else begin
            tp_next = tp + LW'(1);
          end
        end
      end
      S_FIN: begin
        if (fin_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      primed    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      primed <= primed_next;
      if (fin_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    tp       <= tp_next;
    fp       <= fp_next;
    have_t   <= have_t_next;
    spec_any <= spec_any_next;
    res      <= res_next;
    if (fin_load) begin
      is_match <= res;
    end
  end

`ifndef SYNTHESIS
  // An accepted evaluate always starts a walk.
  a_eval_busy: assert property (@(posedge clk) disable iff (rst)
    (in_accept && (op == OP_EVAL)) |=> in_stall)
    else $error("evaluate transfer did not start a walk");

  // The walk pointers never run past the stored strings.
  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    walking |-> ((tp <= topic_len) && (fp <= filter_len)))
    else $error("walk pointer past string length");

  // A new result only comes from the final state of a walk.
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_FIN))
    else $error("result appeared without a finished walk");

  // Both buffers are empty once a result has been loaded.
  a_cleared: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ((topic_len == '0) && (filter_len == '0)))
    else $error("buffers not cleared after evaluate");
`endif

endmodule

// ----- hdl/tfwm_buf.sv -----
// One string buffer: byte memory, fill length and a registered read port.
`timescale 1ns / 1ps

module tfwm_buf #(
  parameter int MAX_STRING_BYTES = tfwm_pkg::DEF_MAX_STRING_BYTES,
  parameter int LW = $clog2(MAX_STRING_BYTES + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  tfwm_pkg::buf_ctl_t ctl,
  input  logic [LW-1:0]      rd_addr,
  output logic [7:0]         rd_data,
  output logic [LW-1:0]      len
);
  import tfwm_pkg::*;

  localparam int AW = $clog2(MAX_STRING_BYTES);

  logic [7:0]    mem [0:MAX_STRING_BYTES-1];
  logic          wr_en;
  logic [AW-1:0] rd_index;

  // Zero bytes and bytes past capacity are dropped.
  assign wr_en = ctl.append && (ctl.data != 8'd0) && (len < LW'(MAX_STRING_BYTES));

  // Positions at or past capacity are never used; keep the index in range.
  assign rd_index = (rd_addr < LW'(MAX_STRING_BYTES)) ? rd_addr[AW-1:0] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0;
    end else if (ctl.clear) begin
      len <= '0;
    end else if (wr_en) begin
      len <= len + LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[len[AW-1:0]] <= ctl.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_index];
  end

endmodule

// ----- tb/topic_filter_wildcard_match_tb.sv -----
// Self-checking testbench for the topic filter wildcard matcher, with its own match predictor.
`timescale 1ns / 1ps

module topic_filter_wildcard_match_tb;
  import tfwm_pkg::*;

  // The block is built with its default buffer size, so the predictor uses the same.
  localparam int BUF_BYTES = DEF_MAX_STRING_BYTES;
  // An evaluate on two full buffers of equal length takes up to 101 equality steps and
  // then level steps over both strings, each first letting the buffer read data settle,
  // so SETTLE_CYCLES covers the slowest walk with margin.
  localparam int SETTLE_CYCLES = 2000;
  localparam logic [7:0] LETTER_A = 8'h61;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] op = OP_NOP;
  logic [7:0] char_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       is_match;

  topic_filter_wildcard_match uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .char_byte (char_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .is_match  (is_match)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor state: our own copy of both string buffers and their fill counts.
  logic [7:0] topic_buf [BUF_BYTES];
  logic [7:0] filter_buf [BUF_BYTES];
  int topic_cnt = 0;
  int filter_cnt = 0;

  // Match results predicted for accepted evaluates, oldest first.
  bit pending_match [$];

  // Sender and receiver pacing knobs, changed by the tests as they go.
  int gap_max = 0;      // longest idle gap between bursts; zero means back to back
  int burst_left = 0;
  int stall_pct = 0;    // chance in percent that the receiver starts a stall run
  int stall_run = 0;
  int sent_count = 0;   // transfers that carry an append or an evaluate
  int mismatch_count = 0;

  // Scratch byte strings used to build one topic/filter pair.
  logic [7:0] topic_q [$];
  logic [7:0] filter_q [$];
  logic [7:0] level_q [$];

  function automatic logic [7:0] buf_byte(input bit from_filter, input int idx);
    return from_filter ? filter_buf[idx] : topic_buf[idx];
  endfunction

  // Moves pos past any separators and then across one level. Returns 0 when the
  // string holds no further non-empty level.
  function automatic bit next_level(input bit from_filter, inout int pos,
                                    output int start, output int len);
    int cnt;
    cnt = from_filter ? filter_cnt : topic_cnt;
    while (pos < cnt && buf_byte(from_filter, pos) == SEP_BYTE) pos++;
    start = pos;
    len = 0;
    if (pos >= cnt) return 1'b0;
    while (pos < cnt && buf_byte(from_filter, pos) != SEP_BYTE) pos++;
    len = pos - start;
    return 1'b1;
  endfunction

  // Works out whether the stored topic matches the stored filter.
  function automatic bit compute_match();
    int tpos, fpos, ts, tl, fs, fl;
    bit have_t, have_f, same;
    tpos = 0;
    fpos = 0;
    // Identical strings match outright, wildcards or not.
    if (topic_cnt == filter_cnt) begin
      same = 1'b1;
      for (int i = 0; i < topic_cnt; i++)
        if (topic_buf[i] != filter_buf[i]) same = 1'b0;
      if (same) return 1'b1;
    end
    have_t = next_level(1'b0, tpos, ts, tl);
    have_f = next_level(1'b1, fpos, fs, fl);
    while (have_f) begin
      // A lone '*' level swallows everything left in the topic, even nothing.
      if (fl == 1 && filter_buf[fs] == ANY_REST_BYTE) return 1'b1;
      if (!have_t) return 1'b0;
      // A lone '+' level stands for any single topic level; others must be equal.
      if (!(fl == 1 && filter_buf[fs] == ONE_LEVEL_BYTE)) begin
        if (tl != fl) return 1'b0;
        for (int i = 0; i < tl; i++)
          if (topic_buf[ts + i] != filter_buf[fs + i]) return 1'b0;
      end
      have_t = next_level(1'b0, tpos, ts, tl);
      have_f = next_level(1'b1, fpos, fs, fl);
    end
    // The filter ran out, so the topic must have run out with it.
    return !have_t;
  endfunction

  // Updates the predictor for one accepted transfer. Zero bytes and bytes that
  // find a full buffer are dropped; an evaluate queues its answer and clears both.
  task automatic apply_transfer(input op_t o, input logic [7:0] b);
    case (o)
      OP_TOPIC: begin
        if (b != 8'h00 && topic_cnt < BUF_BYTES) begin
          topic_buf[topic_cnt] = b;
          topic_cnt++;
        end
      end
      OP_FILTER: begin
        if (b != 8'h00 && filter_cnt < BUF_BYTES) begin
          filter_buf[filter_cnt] = b;
          filter_cnt++;
        end
      end
      OP_EVAL: begin
        pending_match.push_back(compute_match());
        topic_cnt = 0;
        filter_cnt = 0;
      end
      default: begin
      end
    endcase
  endtask

  // Offers one item and waits until the block takes it. The sender runs in bursts;
  // at the start of each burst it may sit idle for a random number of cycles. Valid
  // stays high from one item to the next inside a burst.
  task automatic send_item(input op_t o, input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid  <= 1'b1;
    op        <= o;
    char_byte <= b;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    apply_transfer(o, b);
    if (o != OP_NOP) sent_count++;
  endtask

  // Holds off the sender until every predicted result has been seen. Always waits
  // on the clock before checking, so valid is never lowered and raised in one step.
  task automatic drain_results();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending_match.size() != 0);
  endtask

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("%0t ns: ERROR: %s", $time, what);
  endtask

  // Receiver: checks each result transfer against the oldest prediction and
  // drives out_stall in runs of random length whose frequency the tests set.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (pending_match.size() == 0) begin
          report_mismatch($sformatf("result is_match=%b with no evaluate pending", is_match));
        end else begin
          if (is_match !== pending_match[0])
            report_mismatch($sformatf("is_match=%b, predicted %b", is_match, pending_match[0]));
          void'(pending_match.pop_front());
        end
      end
      if (stall_run > 0) begin
        stall_run--;
        out_stall <= 1'b1;
      end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
        stall_run = $urandom_range(0, 7);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Loads a topic and a filter given as text and then evaluates them.
  task automatic match_strings(input string topic, input string filter);
    for (int i = 0; i < topic.len(); i++) send_item(OP_TOPIC, topic[i]);
    for (int i = 0; i < filter.len(); i++) send_item(OP_FILTER, filter[i]);
    send_item(OP_EVAL, 8'($urandom_range(0, 255)));
  endtask

  // Empty strings: both empty, an empty topic against a filter with no levels,
  // a lone '*' and a lone '+', a topic against an empty filter, and a topic with only separators.
  task automatic test_empty_strings();
    gap_max = 0;
    stall_pct = 0;
    match_strings("", "");
    match_strings("", "/");
    match_strings("", "*");
    match_strings("", "+");
    match_strings("a", "");
    match_strings("//", "");
  endtask

  // Single-level and multi-level wildcards, skipped empty levels, length mismatches,
  // and wildcard characters that are only part of a level.
  task automatic test_wildcard_levels();
    gap_max = 3;
    stall_pct = 40;
    match_strings("a/b/c", "a/+/c");
    match_strings("a/b/c", "a/*");
    match_strings("a", "a/*");
    match_strings("a/b", "+");
    match_strings("a/b", "+/+");
    match_strings("a//b/", "/a/b");
    match_strings("a/b", "a/b/c");
    match_strings("ab/c", "a*/c");
    match_strings("x/+", "x/+");
    match_strings("abc", "abd");
  endtask

  // Byte extremes: zero bytes are dropped, all-ones and high-bit bytes are kept,
  // the unused operation leaves the strings alone.
  task automatic test_byte_extremes();
    gap_max = 1;
    stall_pct = 80;
    send_item(OP_TOPIC, 8'hFF);
    send_item(OP_TOPIC, 8'h00);
    send_item(OP_TOPIC, 8'h80);
    send_item(OP_NOP, 8'hFF);
    send_item(OP_TOPIC, 8'h01);
    send_item(OP_FILTER, 8'hFF);
    send_item(OP_FILTER, 8'h80);
    send_item(OP_NOP, 8'h00);
    send_item(OP_FILTER, 8'h01);
    send_item(OP_EVAL, 8'hFF);
    send_item(OP_FILTER, 8'h00);
    send_item(OP_FILTER, 8'h00);
    send_item(OP_EVAL, 8'h00);
  endtask

  // Fills level_q with one level of one to three bytes, mostly from a tiny
  // alphabet so that levels often collide, sometimes '+' or any byte at all.
  task automatic make_level();
    level_q.delete();
    repeat ($urandom_range(1, 3)) begin
      case ($urandom_range(0, 9))
        0: level_q.push_back(8'($urandom_range(0, 255)));
        1: level_q.push_back(ONE_LEVEL_BYTE);
        default: level_q.push_back(LETTER_A + 8'($urandom_range(0, 2)));
      endcase
    end
  endtask

  // Builds a topic and a filter derived from it level by level, with some levels
  // turned into wildcards, changed or dropped, then sends their bytes interleaved
  // in random order and evaluates. A few pairs are long enough to overflow.
  task automatic send_pair();
    int n_levels;
    bit filter_done;
    topic_q.delete();
    filter_q.delete();
    filter_done = 1'b0;
    n_levels = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 45) : $urandom_range(0, 4);
    for (int i = 0; i < n_levels; i++) begin
      make_level();
      if (i > 0) begin
        topic_q.push_back(SEP_BYTE);
        if (!filter_done) filter_q.push_back(SEP_BYTE);
        if ($urandom_range(0, 9) == 0) topic_q.push_back(SEP_BYTE);
      end
      foreach (level_q[k]) topic_q.push_back(level_q[k]);
      if (!filter_done) begin
        case ($urandom_range(0, 19))
          0, 1, 2: filter_q.push_back(ONE_LEVEL_BYTE);
          3: begin
            filter_q.push_back(ANY_REST_BYTE);
            filter_done = 1'b1;
          end
          4: begin
            foreach (level_q[k]) filter_q.push_back(level_q[k]);
            filter_q.push_back(LETTER_A);
          end
          5: begin
          end
          default: foreach (level_q[k]) filter_q.push_back(level_q[k]);
        endcase
      end
    end
    if (!filter_done && $urandom_range(0, 9) == 0) begin
      filter_q.push_back(SEP_BYTE);
      case ($urandom_range(0, 2))
        0: filter_q.push_back(ANY_REST_BYTE);
        1: filter_q.push_back(ONE_LEVEL_BYTE);
        default: filter_q.push_back(LETTER_A);
      endcase
    end
    if ($urandom_range(0, 5) == 0) topic_q.push_front(SEP_BYTE);
    if ($urandom_range(0, 5) == 0) filter_q.push_back(SEP_BYTE);

    while (topic_q.size() + filter_q.size() > 0) begin
      if ($urandom_range(0, 39) == 0) send_item(OP_NOP, 8'($urandom_range(0, 255)));
      if (filter_q.size() == 0 || (topic_q.size() != 0 && $urandom_range(0, 1) == 1))
        send_item(OP_TOPIC, topic_q.pop_front());
      else
        send_item(OP_FILTER, filter_q.pop_front());
    end
    send_item(OP_EVAL, 8'($urandom_range(0, 255)));
  endtask

  // A short run of fully random operations and bytes, evaluates included.
  task automatic send_noise();
    repeat ($urandom_range(1, 8))
      send_item(op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
  endtask

  // Random part: mostly well-formed pairs, some noise, with the pacing of both
  // sides reshuffled now and then, and occasional full drains of the results.
  task automatic test_random_sequences(input int n_items);
    int first;
    first = sent_count;
    while (sent_count - first < n_items) begin
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 3))
          0: gap_max = 0;
          1: gap_max = 2;
          2: gap_max = 6;
          default: gap_max = 1;
        endcase
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 20;
          default: stall_pct = 60;
        endcase
      end
      if ($urandom_range(0, 9) == 0) send_noise();
      else send_pair();
      if ($urandom_range(0, 11) == 0) drain_results();
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_empty_strings();
    test_wildcard_levels();
    drain_results();
    test_byte_extremes();
    test_random_sequences(800);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Guard against a hung handshake; far beyond the slowest correct run.
  initial begin
    #10ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
